// ===== design/ascii_hex_checksum_framer_assert.svh =====
// Assertion macros shared by the framer RTL.
`ifndef ASCII_HEX_CHECKSUM_FRAMER_ASSERT_SVH
`define ASCII_HEX_CHECKSUM_FRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define AHCF_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define AHCF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define AHCF_ASSERT_IMPL(name, clk, rst, ante, cons)
`define AHCF_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== design/ahcf_pkg.sv =====
// Types, codes and helpers for the ASCII hex checksum framer.
package ahcf_pkg;

   localparam logic [7:0] FRAME_HEADER = 8'h1A;
   localparam logic [7:0] ASCII_CR     = 8'h0D;
   localparam logic [7:0] ASCII_LF     = 8'h0A;
   localparam logic [7:0] ASCII_ZERO   = 8'h30;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;

   // byte that the sequencer emits next for the held request
   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_PAYLOAD = 3'd1;
   localparam logic [2:0] PH_CHK_HI  = 3'd2;
   localparam logic [2:0] PH_CHK_LO  = 3'd3;
   localparam logic [2:0] PH_CR      = 3'd4;
   localparam logic [2:0] PH_LF      = 3'd5;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      if (nibble < 4'd10) begin
         hex_char = ASCII_ZERO + {4'd0, nibble};
      end else begin
         hex_char = ASCII_UPPER_A + {4'd0, nibble} - 8'd10;
      end
   endfunction

endpackage

// ===== design/ahcf_in_reg.sv =====
// Input register holding one request until the sequencer has emitted all its bytes.
module ahcf_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  logic                   item_release,
   output logic                   item_valid,
   output ahcf_pkg::byte_item_type item
);
   import ahcf_pkg::*;

   logic          valid_ff, valid_in;
   byte_item_type item_ff, item_in;

   assign req_tready = !valid_ff || item_release;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (item_release) begin
         valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
         item_in  = '{data: req_tdata, last: req_tlast};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== design/ahcf_seq.sv =====
// Frame sequencer: picks header, payload, checksum, CR or LF and keeps the running sum.
module ahcf_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  ahcf_pkg::byte_item_type item,
   output logic                    item_release,
   output logic                    emit_valid,
   output ahcf_pkg::byte_item_type emit,
   input  logic                    out_ready
);
   import ahcf_pkg::*;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] chk;
   logic       fire;

   assign chk  = 8'd0 - sum_ff;
   assign fire = item_valid && out_ready;
   assign emit_valid = item_valid;

   always_comb begin
      phase_in     = phase_ff;
      sum_in       = sum_ff;
      item_release = 1'b0;
      emit.data    = item.data;
      emit.last    = 1'b0;
      case (phase_ff)
         PH_HEADER: begin
            emit.data = FRAME_HEADER;
            if (fire) begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            emit.data = item.data;
            if (fire) begin
               sum_in = sum_ff + item.data;
               if (item.last) begin
                  phase_in = PH_CHK_HI;
               end else begin
                  item_release = 1'b1;
               end
            end
         end
         PH_CHK_HI: begin
            emit.data = hex_char(chk[7:4]);
            if (fire) begin
               phase_in = PH_CHK_LO;
            end
         end
         PH_CHK_LO: begin
            emit.data = hex_char(chk[3:0]);
            if (fire) begin
               phase_in = PH_CR;
            end
         end
         PH_CR: begin
            emit.data = ASCII_CR;
            if (fire) begin
               phase_in = PH_LF;
            end
         end
         PH_LF: begin
            emit.data = ASCII_LF;
            emit.last = 1'b1;
            if (fire) begin
               // close the packet and wait for the next header
               phase_in     = PH_HEADER;
               sum_in       = 8'd0;
               item_release = 1'b1;
            end
         end
         default: begin
            phase_in = PH_HEADER;
            sum_in   = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         sum_ff   <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

// ===== design/ahcf_out_reg.sv =====
// Output register toward the result channel.
module ahcf_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    emit_valid,
   input  ahcf_pkg::byte_item_type emit,
   output logic                    out_ready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tlast
);
   import ahcf_pkg::*;

   logic          valid_ff, valid_in;
   byte_item_type data_ff, data_in;

   assign out_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (out_ready) begin
         valid_in = emit_valid;
         data_in  = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff.data;
   assign rsp_tlast  = data_ff.last;

endmodule

// ===== design/ascii_hex_checksum_framer.sv =====
// Top level of the ASCII hex checksum framer.
//
// Requests arrive on req_*: one command byte per request, req_tlast set on the
// final byte of a packet. Results leave on rsp_*: the framed byte stream,
// header 0x1A, the payload bytes, the two's complement byte sum as two
// uppercase hex characters, CR and LF; rsp_tlast marks the LF.
// A request is held in an input register; the sequencer emits one byte per
// cycle from it into the output register while that register has room.
// The first byte of a request reaches rsp_* through the input and output registers.
// Each request yields its payload byte, preceded by the header for the first
// byte of a packet and followed by the two checksum characters, CR and LF for
// the last. The input register takes a new request when empty or as the
// sequencer emits the last byte of the held one.
// Reset clears the running sum and puts the block outside a packet; both
// registers come up empty.
// When the receiver stalls, the output register holds its byte, the sequencer
// stops, and req_tready drops once the input register is full.
`include "ascii_hex_checksum_framer_assert.svh"

module ascii_hex_checksum_framer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] command_byte
   input  logic       req_tlast,   // payload_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] frame_byte
   output logic       rsp_tlast    // frame_end
);
   import ahcf_pkg::*;

   logic          item_valid;
   logic          item_release;
   byte_item_type item;
   logic          emit_valid;
   byte_item_type emit;
   logic          out_ready;

   ahcf_in_reg u_in_reg (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .item_release (item_release),
      .item_valid   (item_valid),
      .item         (item)
   );

   ahcf_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item         (item),
      .item_release (item_release),
      .emit_valid   (emit_valid),
      .emit         (emit),
      .out_ready    (out_ready)
   );

   ahcf_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .emit_valid (emit_valid),
      .emit       (emit),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `AHCF_ASSERT_IMPL(a_last_is_lf, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata == ASCII_LF)
   `AHCF_ASSERT_NEXT(a_item_reaches_out, clock, reset, item_valid && out_ready, rsp_tvalid)
   `AHCF_ASSERT_IMPL(a_release_needs_room, clock, reset, item_release, item_valid && out_ready)

endmodule

// ===== test/ascii_hex_checksum_framer_tb.sv =====
// Testbench for the ASCII hex checksum framer: directed and random packets checked against a byte predictor.
module ascii_hex_checksum_framer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ahcf_pkg::*;

   localparam int ITEM_TARGET = 470;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 80;
   localparam int HOLD_AFTER  = 150;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;  // [7:0] command_byte
   logic       req_tlast = 1'b0;   // payload_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [7:0] frame_byte
   logic       rsp_tlast;          // frame_end

   ascii_hex_checksum_framer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   byte_item_type command_queue[$];
   byte_item_type frame_expect[$];
   byte_item_type req_next;

   logic [7:0] pkt_sum = 8'h00;
   logic       pkt_open = 1'b0;
   logic       req_took = 1'b0;

   int requests_queued = 0;
   int requests_taken = 0;
   int bytes_checked = 0;
   int packets_closed = 0;
   int low_checksums = 0;
   int single_packets = 0;
   int pkt_len = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int req_gap = 0;
   int req_burst = 0;
   int rsp_gap = 0;
   int rsp_burst = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      return (nibble < 4'd10) ? ASCII_ZERO + {4'h0, nibble}
                              : ASCII_UPPER_A + {4'h0, nibble} - 8'd10;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void predict_frame(input logic [7:0] data, input logic last);
      logic [7:0] chk;
      if (!pkt_open) begin
         frame_expect.push_back('{data: FRAME_HEADER, last: 1'b0});
         pkt_open = 1'b1;
         pkt_sum  = 8'h00;
         pkt_len  = 0;
      end
      frame_expect.push_back('{data: data, last: 1'b0});
      pkt_sum = pkt_sum + data;
      pkt_len++;
      if (last) begin
         chk = 8'h00 - pkt_sum;
         frame_expect.push_back('{data: hex_digit(chk[7:4]), last: 1'b0});
         frame_expect.push_back('{data: hex_digit(chk[3:0]), last: 1'b0});
         frame_expect.push_back('{data: ASCII_CR, last: 1'b0});
         frame_expect.push_back('{data: ASCII_LF, last: 1'b1});
         packets_closed++;
         if (chk < 8'h10) low_checksums++;
         if (pkt_len == 1) single_packets++;
         pkt_open = 1'b0;
         pkt_sum  = 8'h00;
      end
   endfunction

   function automatic void check_frame_byte(input logic [7:0] data, input logic last);
      byte_item_type want;
      if (frame_expect.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("[%0t] unexpected response byte %02h last %0b", $realtime, data, last);
      end else begin
         want = frame_expect.pop_front();
         if (want.data !== data || want.last !== last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("[%0t] response %0d: expected byte %02h last %0b, got byte %02h last %0b",
                        $realtime, bytes_checked, want.data, want.last, data, last);
         end
      end
      bytes_checked++;
   endfunction

   // monitor: predict on each accepted request, check each accepted response byte
   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            predict_frame(req_tdata, req_tlast);
            requests_taken++;
         end
         if (rsp_tvalid && rsp_tready) check_frame_byte(rsp_tdata, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still expected",
                  cycle_count, frame_expect.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // request driver: hold an offered request until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_took) begin
         req_tvalid <= 1'b1;
      end else if (req_gap > 0) begin
         req_tvalid <= 1'b0;
         req_gap--;
      end else if (command_queue.size() > 0) begin
         req_next = command_queue.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= req_next.data;
         req_tlast  <= req_next.last;
         if (req_burst > 0) begin
            req_burst--;
         end else begin
            req_gap = pick_gap();
            if ($urandom_range(0, 19) == 0) req_burst = $urandom_range(10, 40);
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // response sink: random stalls plus one long hold-off so the input backs up
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (!hold_done && bytes_checked >= HOLD_AFTER) begin
         rsp_tready <= 1'b0;
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_burst > 0) begin
            rsp_burst--;
         end else begin
            rsp_gap = pick_gap();
            if ($urandom_range(0, 19) == 0) rsp_burst = $urandom_range(10, 40);
         end
      end
   end

   task automatic queue_request(input logic [7:0] data, input logic last);
      command_queue.push_back('{data: data, last: last});
      requests_queued++;
   endtask

   // wait until every request is taken and every response byte has arrived
   task automatic drain();
      while (requests_taken != requests_queued || frame_expect.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int         len;
      int         kind;
      logic [7:0] data;
      logic [7:0] gen_sum;
      bit         paused;

      paused = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single-byte packets: checksum 00, 01, FF, 10, F1
      queue_request(8'h00, 1'b1);
      queue_request(8'hFF, 1'b1);
      queue_request(8'h01, 1'b1);
      queue_request(8'hF0, 1'b1);
      queue_request(8'h0F, 1'b1);
      // sum wraps to zero
      queue_request(8'h80, 1'b0);
      queue_request(8'h80, 1'b1);
      // header, CR, LF and '0' as plain payload
      queue_request(FRAME_HEADER, 1'b0);
      queue_request(ASCII_CR, 1'b0);
      queue_request(ASCII_LF, 1'b0);
      queue_request(ASCII_ZERO, 1'b1);
      queue_request(8'hFF, 1'b0);
      queue_request(8'hFF, 1'b0);
      queue_request(8'hFF, 1'b1);
      queue_request(8'hA5, 1'b0);
      queue_request(8'h5A, 1'b1);
      // checksum characters fed back in as payload
      for (int i = 0; i < 6; i++) queue_request(ASCII_UPPER_A + 8'(i), i == 5);
      drain();

      while (requests_queued < ITEM_TARGET) begin
         kind = $urandom_range(0, 9);
         len = (kind < 3) ? 1 : (kind < 8) ? $urandom_range(2, 6) : $urandom_range(7, 24);
         gen_sum = 8'h00;
         for (int i = 0; i < len; i++) begin
            kind = $urandom_range(0, 7);
            data = (kind == 0) ? 8'h00 : (kind == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            // steer some packets to a checksum below 0x10
            if (i == len - 1 && $urandom_range(0, 3) == 0)
               data = 8'h00 - gen_sum - 8'($urandom_range(0, 15));
            gen_sum = gen_sum + data;
            queue_request(data, i == len - 1);
         end
         if (!paused && requests_queued >= ITEM_TARGET / 2) begin
            paused = 1'b1;
            drain();
         end
      end
      drain();
      repeat (20) @(negedge clock);

      $display("%0d requests in %0d packets (%0d single-byte, %0d checksums below 10h)",
               requests_taken, packets_closed, single_packets, low_checksums);
      $display("%0d response bytes checked, %0d mismatches", bytes_checked, mismatch_count);
      if (mismatch_count == 0 && frame_expect.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
